### design/mie_pkg.sv
//------------------------------------------------------------------------------
// mie_pkg
// Types, opcode and function codes and status codes shared by the
// integer execute block.
//------------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] instr_pc;
    } mie_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
        logic        is_control;
        logic        delay_slot_runs;
        logic [31:0] after_pc;
        logic        misaligned;
    } mie_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDB,
        S_EXEC,
        S_MD,
        S_FIN,
        S_OUT
    } mie_state_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_UNIMP   = 2'd1;
    localparam logic [1:0] ST_LEFTOUT = 2'd2;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;
    localparam logic [5:0] OP_DADDI   = 6'h18;
    localparam logic [5:0] OP_DADDIU  = 6'h19;
    localparam logic [5:0] OP_LDL     = 6'h1A;
    localparam logic [5:0] OP_LDR     = 6'h1B;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_LWU     = 6'h27;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2A;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_SDL     = 6'h2C;
    localparam logic [5:0] OP_SDR     = 6'h2D;
    localparam logic [5:0] OP_SWR     = 6'h2E;
    localparam logic [5:0] OP_CACHE   = 6'h2F;
    localparam logic [5:0] OP_LL      = 6'h30;
    localparam logic [5:0] OP_LWC1    = 6'h31;
    localparam logic [5:0] OP_LDC1    = 6'h35;
    localparam logic [5:0] OP_LD      = 6'h37;
    localparam logic [5:0] OP_SC      = 6'h38;
    localparam logic [5:0] OP_SWC1    = 6'h39;
    localparam logic [5:0] OP_SDC1    = 6'h3D;
    localparam logic [5:0] OP_SD      = 6'h3F;

    localparam logic [5:0] FN_SLL    = 6'h00;
    localparam logic [5:0] FN_SRL    = 6'h02;
    localparam logic [5:0] FN_SRA    = 6'h03;
    localparam logic [5:0] FN_SLLV   = 6'h04;
    localparam logic [5:0] FN_SRLV   = 6'h06;
    localparam logic [5:0] FN_SRAV   = 6'h07;
    localparam logic [5:0] FN_JR     = 6'h08;
    localparam logic [5:0] FN_JALR   = 6'h09;
    localparam logic [5:0] FN_MOVZ   = 6'h0A;
    localparam logic [5:0] FN_MOVN   = 6'h0B;
    localparam logic [5:0] FN_SYNC   = 6'h0F;
    localparam logic [5:0] FN_MFHI   = 6'h10;
    localparam logic [5:0] FN_MTHI   = 6'h11;
    localparam logic [5:0] FN_MFLO   = 6'h12;
    localparam logic [5:0] FN_MTLO   = 6'h13;
    localparam logic [5:0] FN_DSLLV  = 6'h14;
    localparam logic [5:0] FN_DSRLV  = 6'h16;
    localparam logic [5:0] FN_DSRAV  = 6'h17;
    localparam logic [5:0] FN_MULT   = 6'h18;
    localparam logic [5:0] FN_MULTU  = 6'h19;
    localparam logic [5:0] FN_DIV    = 6'h1A;
    localparam logic [5:0] FN_DIVU   = 6'h1B;
    localparam logic [5:0] FN_ADD    = 6'h20;
    localparam logic [5:0] FN_ADDU   = 6'h21;
    localparam logic [5:0] FN_SUB    = 6'h22;
    localparam logic [5:0] FN_SUBU   = 6'h23;
    localparam logic [5:0] FN_AND    = 6'h24;
    localparam logic [5:0] FN_OR     = 6'h25;
    localparam logic [5:0] FN_XOR    = 6'h26;
    localparam logic [5:0] FN_NOR    = 6'h27;
    localparam logic [5:0] FN_SLT    = 6'h2A;
    localparam logic [5:0] FN_SLTU   = 6'h2B;
    localparam logic [5:0] FN_DADD   = 6'h2C;
    localparam logic [5:0] FN_DADDU  = 6'h2D;
    localparam logic [5:0] FN_DSUB   = 6'h2E;
    localparam logic [5:0] FN_DSUBU  = 6'h2F;
    localparam logic [5:0] FN_TGE    = 6'h30;
    localparam logic [5:0] FN_TGEU   = 6'h31;
    localparam logic [5:0] FN_TLT    = 6'h32;
    localparam logic [5:0] FN_TLTU   = 6'h33;
    localparam logic [5:0] FN_TEQ    = 6'h34;
    localparam logic [5:0] FN_TNE    = 6'h36;
    localparam logic [5:0] FN_DSLL   = 6'h38;
    localparam logic [5:0] FN_DSRL   = 6'h3A;
    localparam logic [5:0] FN_DSRA   = 6'h3B;
    localparam logic [5:0] FN_DSLL32 = 6'h3C;
    localparam logic [5:0] FN_DSRL32 = 6'h3E;
    localparam logic [5:0] FN_DSRA32 = 6'h3F;

    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZL  = 5'h02;
    localparam logic [4:0] RI_BGEZL  = 5'h03;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    localparam logic [4:0] LINK_REG  = 5'd31;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

### design/mie_ram.sv
//------------------------------------------------------------------------------
// mie_ram
// Generic single write port, single read port RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none

module mie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/mips64_integer_execute_top.sv
//------------------------------------------------------------------------------
// mips64_integer_execute_top
// Integer execute unit: register file, HI/LO, ALU, shifts, mult/div, branches.
//------------------------------------------------------------------------------
// One instruction beat in, one result beat out. Each instruction runs through
// a small sequencer: rs is read from the register file RAM as the beat is
// taken, rt the cycle after, the instruction executes in S_EXEC and the
// result is then held in S_OUT until the consumer takes it. ALU, shift,
// branch and HI/LO moves therefore pass through S_RDB, S_EXEC and S_OUT.
// mult, multu, div and divu run 32 more steps in S_MD through one shared
// 34-bit adder (shift-add or restoring divide, one bit per cycle) plus a
// sign-fix state, S_FIN, before S_OUT; a divide by zero skips the steps. The
// register file is a single-read-port RAM, which is why rs and rt are read in
// turn; its reset to zero is provided by one valid bit per entry, so no
// clearing pass is needed after reset. r0 is never written. cmd_ready is high
// only while the block is idle.
//------------------------------------------------------------------------------
`default_nettype none

module mips64_integer_execute_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire mie_pkg::mie_cmd_t cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output mie_pkg::mie_rsp_t      rsp
);

    import mie_pkg::*;

    mie_state_t state_reg, state_next;

    logic [31:0] instr_reg;
    logic [31:0] pc_reg;
    logic [63:0] a_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [31:0] vld_reg;
    mie_rsp_t    rsp_reg;

    // mult/div iteration state
    logic [63:0] acc_reg;
    logic [31:0] opnd_reg;
    logic [4:0]  cnt_reg;
    logic        mul_reg;
    logic        qneg_reg;
    logic        rneg_reg;

    logic [4:0]  ram_raddr;
    logic [63:0] ram_rdata;
    logic        ram_we;

    // instruction fields
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [63:0] b;

    // decode results
    logic [1:0]  d_status;
    logic        d_wflag;
    logic [4:0]  d_idx;
    logic [63:0] d_val;
    logic        d_ctl, d_runs;
    logic [31:0] d_after;
    logic        d_hi_we, d_lo_we;
    logic        d_md, d_mul, d_signed;

    // ALU datapath
    logic        sub_sel;
    logic [63:0] add_y;
    logic [64:0] sum;
    logic        lt_u, lt_s;
    logic        sh_var, sh_is32;
    logic [5:0]  sh_amt;
    logic [63:0] sh_in, sh_raw, sh_out;
    logic [31:0] pc4, pc8, btarget;
    logic        aneg, take, likely, link;

    // mult/div shared adder
    logic [33:0] md_x, md_y, md_s;
    logic        md_cin;
    logic [63:0] md_acc_next;
    logic [63:0] prod_fix;
    logic [31:0] q_fix, r_fix;
    logic [31:0] ua, ub;

    assign op  = instr_reg[31:26];
    assign rs  = instr_reg[25:21];
    assign rt  = instr_reg[20:16];
    assign rd  = instr_reg[15:11];
    assign sa  = instr_reg[10:6];
    assign fn  = instr_reg[5:0];
    assign imm = instr_reg[15:0];

    // rt arrives from the RAM in S_EXEC; entries never written read as zero
    assign b = vld_reg[rt] ? ram_rdata : 64'd0;

    mie_ram #(
        .WIDTH (64),
        .DEPTH (32)
    ) u_rf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (d_idx),
        .wdata (d_val),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = (state_reg == S_IDLE) ? cmd.instr_word[25:21] : rt;
    assign ram_we    = (state_reg == S_EXEC) && d_wflag;

    //--------------------------------------------------------------------------
    // ALU: one 65-bit adder serves add/sub and the set-less-than compares
    //--------------------------------------------------------------------------
    always_comb
    begin
        sub_sel = 1'b0;
        if (op == OP_SPECIAL)
        begin
            case (fn)
                FN_SUB, FN_SUBU, FN_DSUB, FN_DSUBU, FN_SLT, FN_SLTU: sub_sel = 1'b1;
                default: sub_sel = 1'b0;
            endcase
        end
        else if (op == OP_SLTI || op == OP_SLTIU)
        begin
            sub_sel = 1'b1;
        end
        add_y = (op == OP_SPECIAL) ? b : {{48{imm[15]}}, imm};
        sum   = {1'b0, a_reg} + {1'b0, (sub_sel ? ~add_y : add_y)} + {64'd0, sub_sel};
        lt_u  = ~sum[64];
        lt_s  = (a_reg[63] ^ add_y[63]) ? a_reg[63] : sum[63];
    end

    // shared barrel shifter for the 32- and 64-bit shift families
    always_comb
    begin
        sh_var  = fn[2] && !fn[5];
        sh_is32 = !fn[4] && !fn[5];
        if (sh_var)
        begin
            sh_amt = fn[4] ? a_reg[5:0] : {1'b0, a_reg[4:0]};
        end
        else
        begin
            sh_amt = fn[5] ? {fn[2], sa} : {1'b0, sa};
        end
        if (sh_is32)
        begin
            sh_in = fn[0] ? sx32(b[31:0]) : {32'd0, b[31:0]};
        end
        else
        begin
            sh_in = b;
        end
        case (fn[1:0])
            2'b00:   sh_raw = sh_in << sh_amt;
            2'b11:   sh_raw = $unsigned($signed(sh_in) >>> sh_amt);
            default: sh_raw = sh_in >> sh_amt;
        endcase
        sh_out = sh_is32 ? sx32(sh_raw[31:0]) : sh_raw;
    end

    assign pc4     = pc_reg + 32'd4;
    assign pc8     = pc_reg + 32'd8;
    assign btarget = pc4 + {{14{imm[15]}}, imm, 2'b00};
    assign aneg    = a_reg[63];

    //--------------------------------------------------------------------------
    // Decode and execute (used in S_EXEC)
    //--------------------------------------------------------------------------
    always_comb
    begin
        d_status = ST_DONE;
        d_wflag  = 1'b0;
        d_idx    = 5'd0;
        d_val    = 64'd0;
        d_ctl    = 1'b0;
        d_runs   = 1'b1;
        d_after  = pc4;
        d_hi_we  = 1'b0;
        d_lo_we  = 1'b0;
        d_md     = 1'b0;
        d_mul    = 1'b0;
        d_signed = 1'b0;
        take     = 1'b0;
        likely   = 1'b0;
        link     = 1'b0;

        if (pc_reg[1:0] == 2'b00)
        begin
            case (op)
                OP_J, OP_JAL:
                begin
                    d_ctl   = 1'b1;
                    d_after = {pc4[31:28], instr_reg[25:0], 2'b00};
                    if (op == OP_JAL)
                    begin
                        d_wflag = 1'b1;
                        d_idx   = LINK_REG;
                        d_val   = sx32(pc8);
                    end
                end
                OP_REGIMM:
                begin
                    case (rt)
                        RI_BLTZ:   take = aneg;
                        RI_BGEZ:   take = !aneg;
                        RI_BLTZL:  begin take = aneg;  likely = 1'b1; end
                        RI_BGEZL:  begin take = !aneg; likely = 1'b1; end
                        RI_BLTZAL: begin take = aneg;  link = 1'b1; end
                        RI_BGEZAL: begin take = !aneg; link = 1'b1; end
                        default:   d_status = ST_UNIMP;
                    endcase
                    if (d_status == ST_DONE)
                    begin
                        d_ctl   = 1'b1;
                        d_after = take ? btarget : pc8;
                        d_runs  = !(likely && !take);
                        if (link)
                        begin
                            d_wflag = 1'b1;
                            d_idx   = LINK_REG;
                            d_val   = sx32(pc8);
                        end
                    end
                end
                OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL:
                begin
                    case (op[1:0])
                        2'b00:   take = (a_reg == b);
                        2'b01:   take = (a_reg != b);
                        2'b10:   take = aneg || (a_reg == 64'd0);
                        default: take = !aneg && (a_reg != 64'd0);
                    endcase
                    likely  = op[4];
                    d_ctl   = 1'b1;
                    d_after = take ? btarget : pc8;
                    d_runs  = !(likely && !take);
                end
                OP_SPECIAL:
                begin
                    d_idx = rd;
                    case (fn)
                        FN_JR, FN_JALR:
                        begin
                            d_ctl   = 1'b1;
                            d_after = a_reg[31:0];
                            if (fn == FN_JALR)
                            begin
                                d_wflag = 1'b1;
                                d_val   = sx32(pc8);
                            end
                        end
                        FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
                        FN_DSLLV, FN_DSRLV, FN_DSRAV, FN_DSLL, FN_DSRL, FN_DSRA,
                        FN_DSLL32, FN_DSRL32, FN_DSRA32:
                        begin
                            d_wflag = 1'b1;
                            d_val   = sh_out;
                        end
                        FN_MOVZ:
                        begin
                            d_wflag = (b == 64'd0);
                            d_val   = a_reg;
                        end
                        FN_MOVN:
                        begin
                            d_wflag = (b != 64'd0);
                            d_val   = a_reg;
                        end
                        FN_MFHI:  begin d_wflag = 1'b1; d_val = hi_reg; end
                        FN_MFLO:  begin d_wflag = 1'b1; d_val = lo_reg; end
                        FN_MTHI:  d_hi_we = 1'b1;
                        FN_MTLO:  d_lo_we = 1'b1;
                        FN_MULT, FN_MULTU:
                        begin
                            d_md     = 1'b1;
                            d_mul    = 1'b1;
                            d_signed = !fn[0];
                        end
                        FN_DIV, FN_DIVU:
                        begin
                            // divide by zero leaves HI and LO alone
                            d_md     = (b[31:0] != 32'd0);
                            d_signed = !fn[0];
                        end
                        FN_ADD, FN_ADDU, FN_SUB, FN_SUBU:
                        begin
                            d_wflag = 1'b1;
                            d_val   = sx32(sum[31:0]);
                        end
                        FN_DADD, FN_DADDU, FN_DSUB, FN_DSUBU:
                        begin
                            d_wflag = 1'b1;
                            d_val   = sum[63:0];
                        end
                        FN_AND:  begin d_wflag = 1'b1; d_val = a_reg & b; end
                        FN_OR:   begin d_wflag = 1'b1; d_val = a_reg | b; end
                        FN_XOR:  begin d_wflag = 1'b1; d_val = a_reg ^ b; end
                        FN_NOR:  begin d_wflag = 1'b1; d_val = ~(a_reg | b); end
                        FN_SLT:  begin d_wflag = 1'b1; d_val = {63'd0, lt_s}; end
                        FN_SLTU: begin d_wflag = 1'b1; d_val = {63'd0, lt_u}; end
                        FN_SYNC, FN_TGE, FN_TGEU, FN_TLT, FN_TLTU, FN_TEQ, FN_TNE: ;
                        default: d_status = ST_UNIMP;
                    endcase
                end
                OP_ADDI, OP_ADDIU:
                begin
                    d_wflag = 1'b1;
                    d_idx   = rt;
                    d_val   = sx32(sum[31:0]);
                end
                OP_DADDI, OP_DADDIU:
                begin
                    d_wflag = 1'b1;
                    d_idx   = rt;
                    d_val   = sum[63:0];
                end
                OP_SLTI:  begin d_wflag = 1'b1; d_idx = rt; d_val = {63'd0, lt_s}; end
                OP_SLTIU: begin d_wflag = 1'b1; d_idx = rt; d_val = {63'd0, lt_u}; end
                OP_ANDI:  begin d_wflag = 1'b1; d_idx = rt; d_val = a_reg & {48'd0, imm}; end
                OP_ORI:   begin d_wflag = 1'b1; d_idx = rt; d_val = a_reg | {48'd0, imm}; end
                OP_XORI:  begin d_wflag = 1'b1; d_idx = rt; d_val = a_reg ^ {48'd0, imm}; end
                OP_LUI:   begin d_wflag = 1'b1; d_idx = rt; d_val = sx32({imm, 16'd0}); end
                OP_COP0, OP_CACHE: ;
                OP_COP1, OP_LDL, OP_LDR, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU,
                OP_LWR, OP_LWU, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SDL, OP_SDR, OP_SWR,
                OP_LL, OP_LWC1, OP_LDC1, OP_LD, OP_SC, OP_SWC1, OP_SDC1, OP_SD:
                    d_status = ST_LEFTOUT;
                default: d_status = ST_UNIMP;
            endcase
        end

        // r0 stays zero: a write to it is dropped and not reported
        if (d_idx == 5'd0)
        begin
            d_wflag = 1'b0;
        end
        if (!d_wflag)
        begin
            d_idx = 5'd0;
            d_val = 64'd0;
        end
    end

    //--------------------------------------------------------------------------
    // mult/div: one bit per cycle through a shared 34-bit adder
    //   mult: acc = {partial, multiplier}, shifts right
    //   div : acc = {remainder, quotient}, shifts left (restoring)
    //--------------------------------------------------------------------------
    assign ua = (d_signed && a_reg[31]) ? (32'd0 - a_reg[31:0]) : a_reg[31:0];
    assign ub = (d_signed && b[31])     ? (32'd0 - b[31:0])     : b[31:0];

    always_comb
    begin
        if (mul_reg)
        begin
            md_x   = {2'b00, acc_reg[63:32]};
            md_y   = {2'b00, opnd_reg};
            md_cin = 1'b0;
        end
        else
        begin
            md_x   = {1'b0, acc_reg[63:31]};
            md_y   = {1'b0, ~{1'b0, opnd_reg}};
            md_cin = 1'b1;
        end
        md_s = md_x + md_y + {33'd0, md_cin};
        if (mul_reg)
        begin
            md_acc_next = acc_reg[0] ? {md_s[32:0], acc_reg[31:1]}
                                     : {1'b0, acc_reg[63:1]};
        end
        else
        begin
            md_acc_next = md_s[33] ? {md_s[31:0], acc_reg[30:0], 1'b1}
                                   : {acc_reg[62:0], 1'b0};
        end
        prod_fix = qneg_reg ? (64'd0 - acc_reg) : acc_reg;
        q_fix    = qneg_reg ? (32'd0 - acc_reg[31:0])  : acc_reg[31:0];
        r_fix    = rneg_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];
    end

    //--------------------------------------------------------------------------
    // Sequencer
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        rsp_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    state_next = S_RDB;
                end
            end
            S_RDB:  state_next = S_EXEC;
            S_EXEC: state_next = d_md ? S_MD : S_OUT;
            S_MD:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:  state_next = S_OUT;
            S_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign rsp = rsp_reg;

    // valid bits give the register file its reset value of zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 32'd0;
            hi_reg  <= 64'd0;
            lo_reg  <= 64'd0;
        end
        else
        begin
            if (ram_we)
            begin
                vld_reg[d_idx] <= 1'b1;
            end
            if (state_reg == S_EXEC && d_hi_we)
            begin
                hi_reg <= a_reg;
            end
            if (state_reg == S_EXEC && d_lo_we)
            begin
                lo_reg <= a_reg;
            end
            if (state_reg == S_FIN)
            begin
                if (mul_reg)
                begin
                    lo_reg <= sx32(prod_fix[31:0]);
                    hi_reg <= sx32(prod_fix[63:32]);
                end
                else
                begin
                    lo_reg <= sx32(q_fix);
                    hi_reg <= sx32(r_fix);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                instr_reg <= cmd.instr_word;
                pc_reg    <= cmd.instr_pc;
            end
            S_RDB:
            begin
                a_reg <= vld_reg[rs] ? ram_rdata : 64'd0;
            end
            S_EXEC:
            begin
                rsp_reg.status          <= d_status;
                rsp_reg.reg_write       <= d_wflag;
                rsp_reg.reg_index       <= d_idx;
                rsp_reg.reg_value       <= d_val;
                rsp_reg.is_control      <= d_ctl;
                rsp_reg.delay_slot_runs <= d_runs;
                rsp_reg.after_pc        <= d_after;
                rsp_reg.misaligned      <= (pc_reg[1:0] != 2'b00) ||
                                           (d_ctl && d_after[1:0] != 2'b00);
                mul_reg  <= d_mul;
                qneg_reg <= d_signed && (a_reg[31] ^ b[31]);
                rneg_reg <= d_signed && a_reg[31];
                cnt_reg  <= 5'd31;
                opnd_reg <= d_mul ? ua : ub;
                acc_reg  <= {32'd0, d_mul ? ub : ua};
            end
            S_MD:
            begin
                acc_reg <= md_acc_next;
                cnt_reg <= cnt_reg - 5'd1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
